### sv/tae_pkg.sv
package tae_pkg;

	// operation codes
	localparam logic [3:0] OP_ADC      = 4'd0;
	localparam logic [3:0] OP_ADD_REG  = 4'd1;
	localparam logic [3:0] OP_ADD_IMM  = 4'd2;
	localparam logic [3:0] OP_ADD_SP   = 4'd3;
	localparam logic [3:0] OP_ADD_REG2 = 4'd4;
	localparam logic [3:0] OP_ADR      = 4'd5;
	localparam logic [3:0] OP_AND      = 4'd6;
	localparam logic [3:0] OP_ASR_REG  = 4'd7;
	localparam logic [3:0] OP_ASR_IMM  = 4'd8;
	localparam logic [3:0] OP_B        = 4'd9;
	localparam logic [3:0] OP_BL_PRE   = 4'd10;
	localparam logic [3:0] OP_BL_SUF   = 4'd11;
	localparam logic [3:0] OP_BLX      = 4'd12;
	localparam logic [3:0] OP_BX       = 4'd13;

	// special register indexes
	localparam logic [3:0] REG_SP = 4'd13;
	localparam logic [3:0] REG_LR = 4'd14;
	localparam logic [3:0] REG_PC = 4'd15;

	localparam int IN_BITS  = 39;
	localparam int OUT_BITS = 75;

	// one request, last field in the lowest bits
	typedef struct packed {
		logic              bl_sign;
		logic signed [10:0] branch_offset;
		logic [10:0]       imm;
		logic [3:0]        rn;
		logic [3:0]        rm;
		logic [3:0]        rd;
		logic [3:0]        op;
	} in_item_t;

	// one result, last field in the lowest bits
	typedef struct packed {
		logic        thumb_bit;
		logic        flag_v;
		logic        flag_c;
		logic        flag_z;
		logic        flag_n;
		logic [31:0] pc_value;
		logic        link_written;
		logic [31:0] reg_value;
		logic [3:0]  reg_index;
		logic        reg_written;
	} out_item_t;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

	// state updates from the execute logic
	typedef struct packed {
		logic        rf_we;
		logic [3:0]  rf_idx;
		logic [31:0] rf_data;
		logic        pc_we;
		logic [31:0] pc_data;
		flags_t      flags;
		logic        thumb;
		logic [10:0] latch;
	} upd_t;

	// first operand: rn for the three-operand adds, rd otherwise
	function automatic logic [3:0] opa_index(input logic [3:0] op, input logic [3:0] rd,
		input logic [3:0] rn);
		logic [3:0] idx;
		idx = rd;
		if (op == OP_ADD_REG || op == OP_ADD_IMM) begin
			idx = rn;
		end
		return idx;
	endfunction

endpackage

### sv/thumb_alu_branch_execute.sv
// a request is held in the input stage, then its result is registered in the output register behind m_tvalid
// throughput: one instruction per cycle without output stalls; the register file write, flags and pc
// update in the same cycle the result is registered, so the next request sees them
// output stalls hold the execute stage, and a new request is still taken once it drains
// reset clears the registers, the flags and the bl latch, and sets the T bit
module thumb_alu_branch_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op, rd, rm, rn, imm, branch_offset, bl_sign, zero pad
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// reg_written, reg_index, reg_value, link_written, pc_value,
	// flag_n, flag_z, flag_c, flag_v, thumb_bit, zero pad
	output logic [79:0] m_tdata
);

	tae_pkg::in_item_t  in_item;
	tae_pkg::in_item_t  item_s1;
	logic               valid_s1;
	logic               accept;
	logic               advance;
	logic [31:0]        ra_data;
	logic [31:0]        rb_data;
	logic [31:0]        pc;
	logic [31:0]        sp;
	tae_pkg::flags_t    flags_q;
	logic               thumb_q;
	logic [10:0]        latch_q;
	tae_pkg::upd_t      upd;
	tae_pkg::out_item_t res;
	tae_pkg::out_item_t out_q;
	logic               out_valid_q;

	assign in_item = s_tdata[tae_pkg::IN_BITS-1:0];

	// handshake: execute stage moves on whenever the output register is free
	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept = s_tvalid && s_tready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	// register file, operands read as the request is taken
	tae_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.ra_addr  (tae_pkg::opa_index(in_item.op, in_item.rd, in_item.rn)),
		.rb_addr  (in_item.rm),
		.ra_data  (ra_data),
		.rb_data  (rb_data),
		.wr_en    (advance && upd.rf_we),
		.wr_addr  (upd.rf_idx),
		.wr_data  (upd.rf_data),
		.pc_we    (advance && upd.pc_we),
		.pc_wdata (upd.pc_data),
		.pc       (pc),
		.sp       (sp)
	);

	// execute logic
	tae_exec u_exec (
		.item    (item_s1),
		.ra_data (ra_data),
		.rb_data (rb_data),
		.pc      (pc),
		.sp      (sp),
		.flags   (flags_q),
		.thumb   (thumb_q),
		.latch   (latch_q),
		.upd     (upd),
		.res     (res)
	);

	// flags, T bit and bl latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			thumb_q <= 1'b1;
			latch_q <= '0;
		end else if (advance) begin
			flags_q <= upd.flags;
			thumb_q <= upd.thumb;
			latch_q <= upd.latch;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {5'd0, out_q};

endmodule

### sv/tae_regfile.sv
module tae_regfile (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [3:0]  ra_addr,
	input  logic [3:0]  rb_addr,
	output logic [31:0] ra_data,
	output logic [31:0] rb_data,
	input  logic        wr_en,
	input  logic [3:0]  wr_addr,
	input  logic [31:0] wr_data,
	input  logic        pc_we,
	input  logic [31:0] pc_wdata,
	output logic [31:0] pc,
	output logic [31:0] sp
);

	// r0..r14 live in the array, r15 in its own register
	logic [31:0] mem [16];
	logic [15:0] valid_q;
	logic [31:0] pc_q;
	logic [31:0] sp_q;

	// entry valid bits, cleared by reset so unwritten entries read zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// array write and two registered read ports with write bypass
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			if (wr_en && wr_addr == ra_addr) begin
				ra_data <= wr_data;
			end else begin
				ra_data <= valid_q[ra_addr] ? mem[ra_addr] : '0;
			end
			if (wr_en && wr_addr == rb_addr) begin
				rb_data <= wr_data;
			end else begin
				rb_data <= valid_q[rb_addr] ? mem[rb_addr] : '0;
			end
		end
	end

	// pc and a shadow copy of sp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			sp_q <= '0;
		end else begin
			if (pc_we) begin
				pc_q <= pc_wdata;
			end
			if (wr_en && wr_addr == tae_pkg::REG_SP) begin
				sp_q <= wr_data;
			end
		end
	end

	assign pc = pc_q;
	assign sp = sp_q;

endmodule

### sv/tae_exec.sv
module tae_exec (
	input  tae_pkg::in_item_t  item,
	input  logic [31:0]        ra_data,
	input  logic [31:0]        rb_data,
	input  logic [31:0]        pc,
	input  logic [31:0]        sp,
	input  tae_pkg::flags_t    flags,
	input  logic               thumb,
	input  logic [10:0]        latch,
	output tae_pkg::upd_t      upd,
	output tae_pkg::out_item_t res
);

	logic [3:0]  a_idx;
	logic [31:0] va;
	logic [31:0] vm;
	logic [31:0] add_a;
	logic [31:0] add_b;
	logic        add_cin;
	logic [32:0] sum;
	logic        add_v;
	logic [31:0] asr_x;
	logic [10:0] asr_n;
	logic [4:0]  asr_n5;
	logic [31:0] asr_r;
	logic        asr_c;
	logic [31:0] shifted;
	logic [31:0] boff_ext;
	logic [31:0] bl_off;
	logic        wr;
	logic [31:0] wval;
	logic [31:0] wval_pc;

	// operand select, r15 reads the live pc
	always_comb begin
		a_idx = tae_pkg::opa_index(item.op, item.rd, item.rn);
		va = (a_idx == tae_pkg::REG_PC) ? pc : ra_data;
		vm = (item.rm == tae_pkg::REG_PC) ? pc : rb_data;
	end

	// shared adder with carry and overflow
	always_comb begin
		add_a = va;
		add_b = vm;
		add_cin = 1'b0;
		case (item.op)
			tae_pkg::OP_ADC: begin
				add_cin = flags.c;
			end
			tae_pkg::OP_ADD_REG: begin
				add_a = vm;
				add_b = va;
			end
			tae_pkg::OP_ADD_IMM: begin
				add_b = {21'd0, item.imm};
			end
			tae_pkg::OP_ADD_SP: begin
				add_a = sp;
				add_b = {19'd0, item.imm, 2'b00};
			end
			tae_pkg::OP_ADR: begin
				add_a = {pc[31:2], 2'b00};
				add_b = {19'd0, item.imm, 2'b00};
			end
			default: begin
			end
		endcase
		sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
		add_v = (add_a[31] ^ sum[31]) & (add_b[31] ^ sum[31]);
	end

	// arithmetic shift right with carry out
	always_comb begin
		if (item.op == tae_pkg::OP_ASR_REG) begin
			asr_x = va;
			asr_n = {3'd0, vm[7:0]};
		end else begin
			asr_x = vm;
			asr_n = (item.imm == 11'd0) ? 11'd32 : item.imm;
		end
		asr_n5 = asr_n[4:0];
		shifted = $unsigned($signed(asr_x) >>> asr_n5);
		if (asr_n == 11'd0) begin
			asr_r = asr_x;
			asr_c = flags.c;
		end else if (asr_n[10:5] != 6'd0) begin
			asr_r = {32{asr_x[31]}};
			asr_c = asr_x[31];
		end else begin
			asr_r = shifted;
			asr_c = asr_x[asr_n5 - 5'd1];
		end
	end

	// branch offsets
	always_comb begin
		boff_ext = {{20{item.branch_offset[10]}}, item.branch_offset, 1'b0};
		bl_off = {{10{item.bl_sign}}, item.imm[9:0], latch, 1'b0};
	end

	// per-operation result and state update
	always_comb begin
		upd.rf_we = 1'b0;
		upd.rf_idx = '0;
		upd.rf_data = '0;
		upd.pc_we = 1'b0;
		upd.pc_data = '0;
		upd.flags = flags;
		upd.thumb = thumb;
		upd.latch = latch;
		res = '0;
		wr = 1'b0;
		wval = '0;
		unique case (item.op)
			tae_pkg::OP_ADC, tae_pkg::OP_ADD_IMM: begin
				wr = 1'b1;
				wval = sum[31:0];
				upd.flags = '{n: sum[31], z: sum[31:0] == 32'd0, c: sum[32], v: add_v};
			end
			tae_pkg::OP_ADD_REG: begin
				wr = 1'b1;
				wval = sum[31:0];
				if (item.rd != tae_pkg::REG_PC) begin
					upd.flags = '{n: sum[31], z: sum[31:0] == 32'd0, c: sum[32], v: add_v};
				end
			end
			tae_pkg::OP_ADD_SP, tae_pkg::OP_ADR, tae_pkg::OP_ADD_REG2: begin
				wr = 1'b1;
				wval = sum[31:0];
			end
			tae_pkg::OP_AND: begin
				wr = 1'b1;
				wval = va & vm;
				upd.flags.n = wval[31];
				upd.flags.z = (wval == 32'd0);
			end
			tae_pkg::OP_ASR_REG, tae_pkg::OP_ASR_IMM: begin
				wr = 1'b1;
				wval = asr_r;
				upd.flags.n = asr_r[31];
				upd.flags.z = (asr_r == 32'd0);
				upd.flags.c = asr_c;
			end
			tae_pkg::OP_B: begin
				upd.pc_we = 1'b1;
				upd.pc_data = (pc + boff_ext) & 32'hFFFF_FFFE;
			end
			tae_pkg::OP_BL_PRE: begin
				upd.latch = item.imm;
			end
			tae_pkg::OP_BL_SUF: begin
				upd.rf_we = 1'b1;
				upd.rf_idx = tae_pkg::REG_LR;
				upd.rf_data = pc | 32'd1;
				upd.pc_we = 1'b1;
				upd.pc_data = (pc + bl_off) & 32'hFFFF_FFFE;
				res.reg_written = 1'b1;
				res.link_written = 1'b1;
				res.reg_index = tae_pkg::REG_LR;
				res.reg_value = pc | 32'd1;
			end
			tae_pkg::OP_BLX: begin
				upd.rf_we = 1'b1;
				upd.rf_idx = tae_pkg::REG_LR;
				upd.rf_data = (pc - 32'd2) | 32'd1;
				upd.pc_we = 1'b1;
				upd.pc_data = vm & 32'hFFFF_FFFE;
				upd.thumb = vm[0];
				res.reg_written = 1'b1;
				res.link_written = 1'b1;
				res.reg_index = tae_pkg::REG_LR;
				res.reg_value = (pc - 32'd2) | 32'd1;
			end
			tae_pkg::OP_BX: begin
				upd.pc_we = 1'b1;
				upd.pc_data = vm & 32'hFFFF_FFFE;
				upd.thumb = vm[0];
			end
			default: begin
			end
		endcase

		// data operation writeback, r15 goes to the pc with bit 0 cleared
		wval_pc = wval & 32'hFFFF_FFFE;
		if (wr) begin
			res.reg_written = 1'b1;
			res.reg_index = item.rd;
			if (item.rd == tae_pkg::REG_PC) begin
				upd.pc_we = 1'b1;
				upd.pc_data = wval_pc;
				res.reg_value = wval_pc;
			end else begin
				upd.rf_we = 1'b1;
				upd.rf_idx = item.rd;
				upd.rf_data = wval;
				res.reg_value = wval;
			end
		end

		res.pc_value = upd.pc_we ? upd.pc_data : pc;
		res.flag_n = upd.flags.n;
		res.flag_z = upd.flags.z;
		res.flag_c = upd.flags.c;
		res.flag_v = upd.flags.v;
		res.thumb_bit = upd.thumb;
	end

endmodule

### sv/tae_checker.sv
module tae_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);

	tae_pkg::out_item_t o;

	assign o = m_tdata[tae_pkg::OUT_BITS-1:0];

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// every accepted request is checked for a pending result at m_tvalid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("result missing after request");

	// no register write reports zero index and value
	a_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !o.reg_written |-> o.reg_index == 4'd0 && o.reg_value == 32'd0
			&& !o.link_written)
		else $error("stray write fields");

	// a link write goes to lr with the thumb bit set
	a_link: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o.link_written |-> o.reg_written && o.reg_index == tae_pkg::REG_LR
			&& o.reg_value[0])
		else $error("bad link write");

	// a data write to r15 shows as the new pc with bit 0 clear
	a_pc_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o.reg_written && o.reg_index == tae_pkg::REG_PC
			|-> !o.reg_value[0] && o.pc_value == o.reg_value)
		else $error("pc write mismatch");

endmodule

bind thumb_alu_branch_execute tae_checker u_tae_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
